>>> rtl/fmmp_pkg.sv
package fmmp_pkg;

  // result width and modulus
  localparam int FIB_W = 20;
  localparam logic [FIB_W-1:0] FIB_MOD = 20'd1000000;

  // multiplier digit size and number of digits per product
  localparam int DIGIT_W = 2;
  localparam int MUL_DIGITS = FIB_W / DIGIT_W;

  localparam int DEF_INDEX_BITS = 64;

  typedef struct packed {
    logic             start;
    logic [FIB_W-1:0] x;
    logic [FIB_W-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [FIB_W-1:0] prod;
  } mm_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ISSUE_B,
    S_WAIT_B,
    S_ISSUE_C,
    S_WAIT_C,
    S_ISSUE_X,
    S_WAIT_X,
    S_FINISH
  } fmmp_state_t;

endpackage

>>> rtl/fmmp_modmul.sv
module fmmp_modmul
  import fmmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  localparam int T_W = FIB_W + 3;
  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [FIB_W-1:0] acc;
  logic [FIB_W-1:0] x_r;
  logic [FIB_W-1:0] y_r;

  logic [DIGIT_W-1:0] digit;
  logic [FIB_W+1:0]   dx;
  logic [T_W-1:0]     t;
  logic [T_W-1:0]     r;
  logic               last;

  // radix-4 interleaved step: acc = (4*acc + digit*x) mod m, t stays below 7m
  always_comb begin
    digit = y_r[FIB_W-1 -: DIGIT_W];
    unique case (digit)
      2'd0: dx = '0;
      2'd1: dx = {2'b00, x_r};
      2'd2: dx = {1'b0, x_r, 1'b0};
      default: dx = {2'b00, x_r} + {1'b0, x_r, 1'b0};
    endcase
    t = {1'b0, acc, 2'b00} + {1'b0, dx};
    r = t;
    for (int k = 1; k < 7; k++) begin
      if (t >= T_W'(k) * {3'b000, FIB_MOD}) begin
        r = t - T_W'(k) * {3'b000, FIB_MOD};
      end
    end
    last = (cnt == CNT_W'(MUL_DIGITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= req.x;
      y_r <= req.y;
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      acc <= r[FIB_W-1:0];
      y_r <= {y_r[FIB_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      cnt <= cnt + CNT_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

>>> rtl/fibonacci_mod_matrix_power.sv
// fibonacci_mod_matrix_power: F(index) mod 1000000 by 2x2 matrix square-and-multiply
// each index bit costs three modular products on the one shared
// radix-4 modular multiplier (two bits of the multiplier per cycle)
// one index at a time (in_stall until idle); a finished result waits in the output register
// reset: synchronous active-high rst returns the sequencer to idle and drops out_valid
module fibonacci_mod_matrix_power
  import fmmp_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [63:0]      index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [FIB_W-1:0] fib_mod
);

  localparam int RND_W = $clog2(INDEX_BITS + 1);

  // the accumulated power is kept as [[b+c, b], [b, c]]: b = F(k), c = F(k-1)
  fmmp_state_t state, state_next;
  logic [INDEX_BITS-1:0] n_r, n_r_next;
  logic [RND_W-1:0]      rounds, rounds_next;
  logic [FIB_W-1:0]      b, b_next;
  logic [FIB_W-1:0]      c, c_next;
  logic [FIB_W-1:0]      bsq, bsq_next;      // b*b of this round
  logic [FIB_W-1:0]      sumsq, sumsq_next;  // b*b + c*c, the new c after squaring
  logic                  out_valid_next;
  logic [FIB_W-1:0]      fib_mod_next;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [FIB_W-1:0] b_plus_c;
  logic [FIB_W-1:0] b_plus_2c;
  logic [FIB_W-1:0] sq_b;
  logic [FIB_W-1:0] sq_c;

  function automatic logic [FIB_W-1:0] add_mod(input logic [FIB_W-1:0] x,
                                                input logic [FIB_W-1:0] y);
    logic [FIB_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, FIB_MOD}) begin
      s = s - {1'b0, FIB_MOD};
    end
    return s[FIB_W-1:0];
  endfunction

  fmmp_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  // squaring: new b = b*(a+c) = b*(b+2c), new c = b*b + c*c
  assign b_plus_c  = add_mod(b, c);
  assign b_plus_2c = add_mod(b_plus_c, c);
  assign sq_b      = mm_rsp.prod;
  assign sq_c      = add_mod(bsq, mm_rsp.prod);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_r_next;
    rounds  <= rounds_next;
    b       <= b_next;
    c       <= c_next;
    bsq     <= bsq_next;
    sumsq   <= sumsq_next;
    fib_mod <= fib_mod_next;
  end

  always_comb begin
    state_next   = state;
    n_r_next     = n_r;
    rounds_next  = rounds;
    b_next       = b;
    c_next       = c;
    bsq_next     = bsq;
    sumsq_next   = sumsq;
    fib_mod_next = fib_mod;
    mm_req       = '0;

    // output register drains independently of the sequencer
    out_valid_next = out_valid && out_stall;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          // start from the identity matrix, only the low INDEX_BITS bits count
          n_r_next    = index[INDEX_BITS-1:0];
          rounds_next = RND_W'(INDEX_BITS);
          b_next      = '0;
          c_next      = FIB_W'(1);
          state_next  = S_ISSUE_B;
        end
      end
      S_ISSUE_B: begin
        mm_req.start = 1'b1;
        mm_req.x     = b;
        mm_req.y     = b;
        state_next   = S_WAIT_B;
      end
      S_WAIT_B: begin
        if (mm_rsp.done) begin
          bsq_next   = mm_rsp.prod;
          state_next = S_ISSUE_C;
        end
      end
      S_ISSUE_C: begin
        mm_req.start = 1'b1;
        mm_req.x     = c;
        mm_req.y     = c;
        state_next   = S_WAIT_C;
      end
      S_WAIT_C: begin
        if (mm_rsp.done) begin
          sumsq_next = sq_c;
          state_next = S_ISSUE_X;
        end
      end
      S_ISSUE_X: begin
        mm_req.start = 1'b1;
        mm_req.x     = b;
        mm_req.y     = b_plus_2c;
        state_next   = S_WAIT_X;
      end
      S_WAIT_X: begin
        if (mm_rsp.done) begin
          // index bit set: multiply by [[1,1],[1,0]], which shifts (b, c) to (b+c, b)
          if (n_r[INDEX_BITS-1]) begin
            b_next = add_mod(sq_b, sumsq);
            c_next = sq_b;
          end else begin
            b_next = sq_b;
            c_next = sumsq;
          end
          n_r_next    = n_r << 1;
          rounds_next = rounds - RND_W'(1);
          if (rounds == RND_W'(1)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_ISSUE_B;
          end
        end
      end
      S_FINISH: begin
        // wait for room in the output register
        if (!out_valid || !out_stall) begin
          fib_mod_next   = b;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // every product from the shared unit is fully reduced
  assert property (@(posedge clk) disable iff (rst)
    mm_rsp.done |-> (mm_rsp.prod < FIB_MOD))
    else $error("modular product out of range");

  // matrix entries stay reduced while a transaction is in flight
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE_B || state == S_ISSUE_C || state == S_ISSUE_X || state == S_FINISH)
      |-> (b < FIB_MOD && c < FIB_MOD))
    else $error("matrix entry out of range");

  // a new result only appears when the sequencer finishes
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result produced outside finish");

  // the shared unit is only started by an issue state
  assert property (@(posedge clk) disable iff (rst)
    mm_req.start |=> (state == S_WAIT_B || state == S_WAIT_C || state == S_WAIT_X))
    else $error("multiplier started without a wait state");

endmodule

>>> test/fibonacci_mod_matrix_power_checker.sv
`timescale 1ns / 1ps

module fibonacci_mod_matrix_power_checker
  import fmmp_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [63:0]      index,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [FIB_W-1:0] fib_mod,
  output int               errors,
  output int               pending
);

  localparam logic [63:0] MODULUS = 64'd1000000;

  typedef struct packed {
    logic [63:0] m00;
    logic [63:0] m01;
    logic [63:0] m10;
    logic [63:0] m11;
  } fib_mat_t;

  logic [FIB_W-1:0] fib_expected_q[$];
  int               fail_count;

  function automatic fib_mat_t mat_mul_mod(input fib_mat_t a, input fib_mat_t b);
    fib_mat_t r;
    r.m00 = (a.m00 * b.m00 % MODULUS + a.m01 * b.m10 % MODULUS) % MODULUS;
    r.m01 = (a.m00 * b.m01 % MODULUS + a.m01 * b.m11 % MODULUS) % MODULUS;
    r.m10 = (a.m10 * b.m00 % MODULUS + a.m11 * b.m10 % MODULUS) % MODULUS;
    r.m11 = (a.m10 * b.m01 % MODULUS + a.m11 * b.m11 % MODULUS) % MODULUS;
    return r;
  endfunction

  // square-and-multiply over the low INDEX_BITS bits, msb first
  function automatic logic [FIB_W-1:0] fib_mod_of(input logic [63:0] idx);
    fib_mat_t    step_m;
    fib_mat_t    acc;
    logic [63:0] n;
    n = (INDEX_BITS >= 64) ? idx : (idx & ((64'd1 << INDEX_BITS) - 64'd1));
    if (n <= 64'd1) return n[FIB_W-1:0];
    step_m = {64'd1, 64'd1, 64'd1, 64'd0};
    acc    = {64'd1, 64'd0, 64'd0, 64'd1};
    for (int b = INDEX_BITS - 1; b >= 0; b--) begin
      acc = mat_mul_mod(acc, acc);
      if (n[b]) acc = mat_mul_mod(acc, step_m);
    end
    return acc.m10[FIB_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [FIB_W-1:0] want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (fib_expected_q.size() == 0) begin
          $error("fib_mod: unexpected transaction, expected none, actual %0d", fib_mod);
          fail_count++;
        end else begin
          want = fib_expected_q.pop_front();
          if (fib_mod !== want) begin
            $error("fib_mod: expected %0d, actual %0d", want, fib_mod);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) fib_expected_q.push_back(fib_mod_of(index));
    end
    errors  <= fail_count;
    pending <= fib_expected_q.size();
  end

endmodule

>>> test/fibonacci_mod_matrix_power_test.sv
`timescale 1ns / 1ps

module fibonacci_mod_matrix_power_test;
  import fmmp_pkg::*;

  localparam int IDX_BITS = DEF_INDEX_BITS;
  // one index takes the same time whatever its value
  localparam int LATENCY = 36 * IDX_BITS + 3;
  // long receiver hold-off, several items' worth so the block backs up
  localparam int HOLD_CYCLES = 4 * LATENCY;
  // cycles without any transaction before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2 * HOLD_CYCLES + 4 * LATENCY;
  localparam int RANDOM_PER_PHASE = 128;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [63:0]      index = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [FIB_W-1:0] fib_mod;

  int errors;
  int pending;

  // idle percentages for each side, changed between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  fibonacci_mod_matrix_power #(
    .INDEX_BITS(IDX_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .index    (index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fib_mod  (fib_mod)
  );

  fibonacci_mod_matrix_power_checker #(
    .INDEX_BITS(IDX_BITS)
  ) checker_i (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .index    (index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .fib_mod  (fib_mod),
    .errors   (errors),
    .pending  (pending)
  );

  // receiver: random stalls, plus a counted hold-off whenever one is requested
  initial begin
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // watchdog: any accepted transaction on either side restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one index; returns at the edge where it is taken
  task automatic send_index(input logic [63:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    index    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pause until every outstanding result has come back
  // one edge first so the count includes the index just taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mix of full-width, small, shifted-down and near pisano-period indexes
  function automatic logic [63:0] random_index();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return v;
      1: return 64'($urandom_range(0, 50));
      2: return v >> $urandom_range(1, 63);
      default: return 64'd1500000 * $urandom_range(0, 1000) + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_phase(input int hold_at, input int pause_at);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // receiver backs off for a long stretch while indexes keep coming
      if (i == hold_at) hold_requests <= hold_requests + 1;
      if (i == pause_at) drain();
      send_index(random_index());
    end
    drain();
  endtask

  initial begin
    logic [63:0] directed[$];
    directed = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd10, 64'd30, 64'd31, 64'd999999,
      64'd1500000, 64'd1500001, 64'd3000002,
      64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase one: sender idles a little, receiver a lot
    tx_idle_pct = 16;
    rx_idle_pct = 45;
    foreach (directed[i]) send_index(directed[i]);
    random_phase(40, -1);

    // phase two: the other way round, with a full drain midway
    tx_idle_pct = 45;
    rx_idle_pct = 16;
    random_phase(-1, 60);

    // phase three: back to back on both sides
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(-1, -1);

    drain();
    repeat (LATENCY) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
